// ===== design/cbdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cbdq_pkg
// Shared types and constants for the ring-buffer double-ended queue.
// ----------------------------------------------------------------------------
package cbdq_pkg;

  // Fixed field widths of the channel words
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 10;

  // Operation codes carried in the mode field
  typedef enum logic [MODE_W-1:0] {
    MODE_NONE       = 3'd0,
    MODE_PUSH_FRONT = 3'd1,
    MODE_PUSH_BACK  = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_POP_BACK   = 3'd4
  } mode_e;

  // Control sequencer states
  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_e;

endpackage

// ===== design/cbdq_if.sv =====
// ----------------------------------------------------------------------------
// cbdq_if
// Valid/ready channels for operation words and result words.
// ----------------------------------------------------------------------------
interface cbdq_op_if
  import cbdq_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface cbdq_res_if
  import cbdq_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] popped;
  logic                     pop_ok;
  logic                     push_dropped;
  logic signed [DATA_W-1:0] front_word;
  logic signed [DATA_W-1:0] back_word;
  logic [COUNT_W-1:0]       count;
  logic                     empty_res;
  logic                     full_res;

  modport source (output valid, output popped, output pop_ok, output push_dropped,
                  output front_word, output back_word, output count,
                  output empty_res, output full_res, input ready);
  modport sink   (input valid, input popped, input pop_ok, input push_dropped,
                  input front_word, input back_word, input count,
                  input empty_res, input full_res, output ready);
endinterface

// ===== design/circular_buffer_deque_top.sv =====
// ----------------------------------------------------------------------------
// circular_buffer_deque_top
// Double-ended queue of words in a single-port ring memory with one spare
// slot, so it holds DEPTH-1 words.
// ----------------------------------------------------------------------------
// Each operation word (none, push front, push back, pop front, pop back)
// gives one result word with the popped word, pop/drop flags, the front and
// back words, the count and the empty/full flags. Front and back words are
// cached in registers; the ring memory has one port with a registered read.
// Pushes, no-ops, failed pops and pops that empty the queue load the result
// word when accepted; a pop that leaves words behind first passes ST_READ,
// since the new end word is read from the ring memory. A new operation is
// taken once the previous one is finished and the result register is free
// or being drained. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module circular_buffer_deque_top
  import cbdq_pkg::*;
#(
  parameter int unsigned DEPTH     = 1024,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  cbdq_op_if.sink       in_i,
  cbdq_res_if.source    out_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);

  typedef logic [PTR_W-1:0]     ptr_t;
  typedef logic [WORD_BITS-1:0] word_t;

  // Ring slot arithmetic modulo DEPTH
  function automatic ptr_t slot_next(input ptr_t s);
    if (s == PTR_W'(DEPTH - 1)) return '0;
    return s + PTR_W'(1);
  endfunction

  function automatic ptr_t slot_prev(input ptr_t s);
    if (s == '0) return PTR_W'(DEPTH - 1);
    return s - PTR_W'(1);
  endfunction

  state_e state_q, state_d;
  ptr_t   head_q, head_d;
  ptr_t   tail_q, tail_d;
  ptr_t   count_q, count_d;
  word_t  front_q, front_d;
  word_t  back_q, back_d;
  logic   rd_front_q;

  // Ring memory
  word_t  mem_q [DEPTH];
  word_t  rdata_q;
  logic   mem_we, mem_re;
  ptr_t   mem_waddr, mem_raddr;
  word_t  word_in;

  // Result register
  logic               out_valid_q;
  logic [DATA_W-1:0]  popped_q, front_out_q, back_out_q;
  logic               pop_ok_q, dropped_q, empty_out_q, full_out_q;
  logic [COUNT_W-1:0] count_out_q;

  logic   accept, need_read, rd_front, pop_ok, dropped;
  logic   was_empty, was_full, now_empty, now_full;
  word_t  popped;

  assign accept    = in_i.valid && in_i.ready;
  assign word_in   = WORD_BITS'($unsigned(in_i.value));
  assign was_empty = (head_q == tail_q);
  assign was_full  = (slot_next(tail_q) == head_q);

  // Decode the operation and work out the new ends
  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    front_d   = front_q;
    back_d    = back_q;
    mem_we    = 1'b0;
    mem_waddr = head_q;
    mem_re    = 1'b0;
    mem_raddr = head_q;
    need_read = 1'b0;
    rd_front  = 1'b0;
    pop_ok    = 1'b0;
    dropped   = 1'b0;
    popped    = '0;
    case (in_i.mode)
      MODE_PUSH_FRONT: begin
        if (was_full) begin
          dropped = 1'b1;
        end else begin
          mem_we    = accept;
          mem_waddr = head_q;
          head_d    = slot_prev(head_q);
          count_d   = count_q + PTR_W'(1);
          front_d   = word_in;
          if (was_empty) back_d = word_in;
        end
      end
      MODE_PUSH_BACK: begin
        if (was_full) begin
          dropped = 1'b1;
        end else begin
          mem_we    = accept;
          mem_waddr = slot_next(tail_q);
          tail_d    = slot_next(tail_q);
          count_d   = count_q + PTR_W'(1);
          back_d    = word_in;
          if (was_empty) front_d = word_in;
        end
      end
      MODE_POP_FRONT: begin
        if (!was_empty) begin
          pop_ok    = 1'b1;
          popped    = front_q;
          head_d    = slot_next(head_q);
          count_d   = count_q - PTR_W'(1);
          need_read = (count_q > PTR_W'(1));
          rd_front  = 1'b1;
          mem_re    = accept && need_read;
          mem_raddr = slot_next(slot_next(head_q));
        end
      end
      MODE_POP_BACK: begin
        if (!was_empty) begin
          pop_ok    = 1'b1;
          popped    = back_q;
          tail_d    = slot_prev(tail_q);
          count_d   = count_q - PTR_W'(1);
          need_read = (count_q > PTR_W'(1));
          mem_re    = accept && need_read;
          mem_raddr = slot_prev(tail_q);
        end
      end
      default: begin
      end
    endcase
  end

  assign now_empty = (head_d == tail_d);
  assign now_full  = (slot_next(tail_d) == head_d);

  // Ring memory: one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= word_in;
    if (mem_re) rdata_q <= mem_q[mem_raddr];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept && need_read) state_d = ST_READ;
      ST_READ: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_i.ready = 1'b0;
    case (state_q)
      ST_IDLE: in_i.ready = !out_valid_q || out_o.ready;
      ST_READ: in_i.ready = 1'b0;
      default: in_i.ready = 1'b0;
    endcase
  end

  // Control and pointer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        head_q  <= head_d;
        tail_q  <= tail_d;
        count_q <= count_d;
      end
      if ((accept && !need_read) || state_q == ST_READ) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Cached end words and result word; patch the new end on the read cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      front_q     <= front_d;
      back_q      <= back_d;
      rd_front_q  <= rd_front;
      popped_q    <= DATA_W'(popped);
      pop_ok_q    <= pop_ok;
      dropped_q   <= dropped;
      front_out_q <= now_empty ? '0 : DATA_W'(front_d);
      back_out_q  <= now_empty ? '0 : DATA_W'(back_d);
      count_out_q <= COUNT_W'(count_d);
      empty_out_q <= now_empty;
      full_out_q  <= now_full;
    end else if (state_q == ST_READ) begin
      if (rd_front_q) begin
        front_q     <= rdata_q;
        front_out_q <= DATA_W'(rdata_q);
      end else begin
        back_q      <= rdata_q;
        back_out_q  <= DATA_W'(rdata_q);
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.popped       = popped_q;
  assign out_o.pop_ok       = pop_ok_q;
  assign out_o.push_dropped = dropped_q;
  assign out_o.front_word   = front_out_q;
  assign out_o.back_word    = back_out_q;
  assign out_o.count        = count_out_q;
  assign out_o.empty_res    = empty_out_q;
  assign out_o.full_res     = full_out_q;

  // Count always equals the ring distance from head to tail
  a_count_matches_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(count_q) == ((int'(tail_q) >= int'(head_q)) ?
                       (int'(tail_q) - int'(head_q)) :
                       (int'(tail_q) + int'(DEPTH) - int'(head_q)))))
    else $error("count out of step with head/tail");

  // Count never reaches the spare slot
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) < int'(DEPTH))
    else $error("count exceeds capacity");

  // A pending end-word read always delivers a result next cycle
  a_read_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |=> out_valid_q)
    else $error("read cycle did not produce a result word");

  // Memory reads only issue for a successful pop
  a_read_on_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> (accept && pop_ok))
    else $error("memory read without a pop");

endmodule
